[src/ncr_pkg.sv]
// shared types and constants of the nearest codeword residual unit
package ncr_pkg;

  // fixed field widths
  localparam int MODE_W  = 2;
  localparam int ENTRY_W = 8;
  localparam int ELEM_W  = 7;
  localparam int VAL_W   = 16;
  localparam int IDX_W   = 8;
  localparam int DIST_W  = 39;
  localparam int RES_W   = 17;
  localparam int AENT_W  = 9;
  localparam int ADIM_W  = 8;
  localparam int CFG_W   = 9;
  localparam int CIDX_W  = 1;

  // saturation limits
  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam int RES_MAX = 65535;

  // register reset values
  localparam logic [AENT_W-1:0] AENT_RESET = 9'd256;
  localparam logic [ADIM_W-1:0] ADIM_RESET = 8'd128;

  // item modes
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESID = 2'd2;

  // result kinds
  localparam logic KIND_SEARCH = 1'b0;
  localparam logic KIND_RESID  = 1'b1;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_ACTIVE_ENTRIES = 1'b0;
  localparam logic [CIDX_W-1:0] REG_ACTIVE_DIM     = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic scan_start;
    logic scan_step;
    logic commit;
    logic res_read;
    logic load_search;
    logic load_res;
  } ncr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic query_last;
    logic scan_last;
    logic pipe_empty;
    logic slot_free;
  } ncr_status_t;

endpackage

[src/ncr_ctrl.sv]
// sequencing state machine of the nearest codeword residual unit
module ncr_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  input  logic [ncr_pkg::MODE_W-1:0]      mode,
  input  ncr_pkg::ncr_status_t            status,
  output logic                            item_stall,
  output ncr_pkg::ncr_cmd_t               cmd
);
  import ncr_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SCAN     = 6'b000010,
    ST_DRAIN    = 6'b000100,
    ST_SRCH_OUT = 6'b001000,
    ST_RES_RD   = 6'b010000,
    ST_RES_OUT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.take = 1'b1;
          case (mode)
            MODE_QUERY: begin
              if (status.query_last) begin
                cmd.scan_start = 1'b1;
                state_next     = ST_SCAN;
              end
            end
            MODE_RESID: begin
              state_next = ST_RES_RD;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.pipe_empty) begin
          cmd.commit = 1'b1;
          state_next = ST_SRCH_OUT;
        end
      end
      ST_SRCH_OUT: begin
        if (status.slot_free) begin
          cmd.load_search = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_RES_RD: begin
        cmd.res_read = 1'b1;
        state_next   = ST_RES_OUT;
      end
      ST_RES_OUT: begin
        if (status.slot_free) begin
          cmd.load_res = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[src/ncr_datapath.sv]
// memories, distance pipeline, best tracking and result register
module ncr_datapath #(
  parameter int NUM_WORDS   = 256,
  parameter int DIM         = 128,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [ncr_pkg::CIDX_W-1:0]             cfg_index,
  input  logic [ncr_pkg::CFG_W-1:0]              cfg_data,
  input  logic [ncr_pkg::MODE_W-1:0]             mode,
  input  logic [ncr_pkg::ENTRY_W-1:0]            entry,
  input  logic [ncr_pkg::ELEM_W-1:0]             element,
  input  logic signed [ncr_pkg::VAL_W-1:0]       value,
  input  ncr_pkg::ncr_cmd_t                      cmd,
  output ncr_pkg::ncr_status_t                   status,
  input  logic                                   result_stall,
  output logic                                   result_valid,
  output logic                                   kind,
  output logic [ncr_pkg::IDX_W-1:0]              best_index,
  output logic [ncr_pkg::DIST_W-1:0]             min_distance,
  output logic                                   nonzero_residual,
  output logic signed [ncr_pkg::RES_W-1:0]       residual_value
);
  import ncr_pkg::*;

  localparam int NW       = $clog2(NUM_WORDS);
  localparam int EW       = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int VW       = VALUE_WIDTH;
  localparam int AW       = 2 * VW + EW + 1;
  localparam int CB_DEPTH = NUM_WORDS * (2 ** EW);
  localparam int XW       = (AW > DIST_W) ? AW : DIST_W;
  localparam int RW       = (VW + 1 > 18) ? VW + 1 : 18;
  localparam logic signed [RW-1:0] RMAX = RW'(RES_MAX);
  localparam logic signed [RW-1:0] RMIN = -RMAX;

  // configuration registers
  logic [AENT_W-1:0] active_entries;
  logic [ADIM_W-1:0] active_dim;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= AENT_RESET;
      active_dim     <= ADIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ACTIVE_ENTRIES: active_entries <= cfg_data;
        REG_ACTIVE_DIM:     active_dim     <= cfg_data[ADIM_W-1:0];
        default:            active_entries <= active_entries;
      endcase
    end
  end

  // clamped sizes
  logic [31:0] n_eff;
  logic [31:0] d_eff;
  logic [NW-1:0] i_last;
  logic [EW-1:0] j_last;

  always_comb begin
    if (active_entries == '0) begin
      n_eff = 32'd1;
    end else if (32'(active_entries) > 32'(NUM_WORDS)) begin
      n_eff = 32'(NUM_WORDS);
    end else begin
      n_eff = 32'(active_entries);
    end
    if (active_dim == '0) begin
      d_eff = 32'd1;
    end else if (32'(active_dim) > 32'(DIM)) begin
      d_eff = 32'(DIM);
    end else begin
      d_eff = 32'(active_dim);
    end
  end

  assign i_last = NW'(n_eff - 32'd1);
  assign j_last = EW'(d_eff - 32'd1);

  // item decode
  logic          elem_in_range;
  logic          entry_in_range;
  logic [VW-1:0] wval;
  logic          cb_we;
  logic          q_we;

  assign elem_in_range  = 32'(element) < 32'(DIM);
  assign entry_in_range = 32'(entry) < 32'(NUM_WORDS);
  assign wval           = VW'($unsigned(value));
  assign cb_we          = cmd.take && (mode == MODE_WRITE) && entry_in_range && elem_in_range;
  assign q_we           = cmd.take && (mode == MODE_QUERY) && elem_in_range;

  // item element kept for the residual read
  logic [EW-1:0] elem_q;
  logic          elem_ok;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      elem_q  <= EW'(element);
      elem_ok <= elem_in_range;
    end
  end

  // scan counters
  logic [NW-1:0] scan_i;
  logic [EW-1:0] scan_j;

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_i <= '0;
      scan_j <= '0;
    end else if (cmd.scan_step) begin
      if (scan_j == j_last) begin
        scan_j <= '0;
        scan_i <= scan_i + NW'(1);
      end else begin
        scan_j <= scan_j + EW'(1);
      end
    end
  end

  // nearest codeword state
  logic [NW-1:0]     nearest_index;
  logic [DIST_W-1:0] nearest_distance;

  // memories
  logic [VW-1:0] cb_mem [CB_DEPTH];
  logic [VW-1:0] q_mem  [DIM];
  logic [NW+EW-1:0] cb_wa;
  logic [NW+EW-1:0] cb_ra;
  logic [EW-1:0]    q_ra;
  logic             rd_en;
  logic [VW-1:0]    cb_rd;
  logic [VW-1:0]    q_rd;

  assign cb_wa = {NW'(entry), EW'(element)};
  assign cb_ra = cmd.res_read ? {nearest_index, elem_q} : {scan_i, scan_j};
  assign q_ra  = cmd.res_read ? elem_q : scan_j;
  assign rd_en = cmd.scan_step || cmd.res_read;

  always_ff @(posedge clk) begin
    if (cb_we) begin
      cb_mem[cb_wa] <= wval;
    end
    if (rd_en) begin
      cb_rd <= cb_mem[cb_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[EW'(element)] <= wval;
    end
    if (rd_en) begin
      q_rd <= q_mem[q_ra];
    end
  end

  // stage 1: read data tags
  logic          s1_valid;
  logic          s1_first;
  logic          s1_last;
  logic [NW-1:0] s1_idx;

  // stage 2: squared difference
  logic              s2_valid;
  logic              s2_first;
  logic              s2_last;
  logic [NW-1:0]     s2_idx;
  logic [2*VW-1:0]   sq;
  logic signed [VW:0]      diff;
  logic signed [2*VW+1:0]  prod;

  assign diff = $signed({q_rd[VW-1], q_rd}) - $signed({cb_rd[VW-1], cb_rd});
  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.scan_step;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= (scan_j == '0);
    s1_last  <= (scan_j == j_last);
    s1_idx   <= scan_i;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_idx   <= s1_idx;
    sq       <= prod[2*VW-1:0];
  end

  // stage 3: accumulate and keep the best entry
  logic [AW-1:0] acc;
  logic [AW-1:0] sum;
  logic [AW-1:0] best;
  logic [NW-1:0] bidx;

  assign sum = (s2_first ? '0 : acc) + AW'(sq);

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      acc <= sum;
      // strict compare keeps the lowest index on a tie
      if (s2_last && ((s2_idx == '0) || (sum < best))) begin
        best <= sum;
        bidx <= s2_idx;
      end
    end
  end

  // commit with saturation
  logic [XW-1:0]     best_x;
  logic [DIST_W-1:0] best_sat;

  assign best_x   = XW'(best);
  assign best_sat = (best_x > XW'(DIST_MAX)) ? DIST_MAX : best_x[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      nearest_index    <= '0;
      nearest_distance <= '0;
    end else if (cmd.commit) begin
      nearest_index    <= bidx;
      nearest_distance <= best_sat;
    end
  end

  // residual with saturation
  logic signed [RW-1:0]    res_x;
  logic signed [RW-1:0]    res_sat;
  logic signed [RES_W-1:0] res_out;

  always_comb begin
    res_x = RW'(diff);
    if (res_x > RMAX) begin
      res_sat = RMAX;
    end else if (res_x < RMIN) begin
      res_sat = RMIN;
    end else begin
      res_sat = res_x;
    end
    res_out = elem_ok ? RES_W'(res_sat) : '0;
  end

  // result register
  logic slot_free;

  assign slot_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_search || cmd.load_res) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_search || cmd.load_res) begin
      kind             <= cmd.load_res ? KIND_RESID : KIND_SEARCH;
      best_index       <= IDX_W'(nearest_index);
      min_distance     <= nearest_distance;
      nonzero_residual <= (nearest_distance != '0);
      residual_value   <= cmd.load_res ? res_out : '0;
    end
  end

  assign status.query_last = (32'(element) + 32'd1) == d_eff;
  assign status.scan_last  = (scan_i == i_last) && (scan_j == j_last);
  assign status.pipe_empty = !s1_valid && !s2_valid;
  assign status.slot_free  = slot_free;

endmodule

[src/nearest_codeword_residual_unit.sv]
// top level of the nearest codeword residual unit
// a codebook write or a non-final query element is taken and gives no result; the final query
// element starts a full scan of active_entries x active_dim elements, then a pipeline drain
// and commit, before its search result is shown; a residual read fetches the kept element
// of the nearest entry and of the query, then shows the residual; one item is in work at a
// time, scanning one codebook element per cycle through the single codebook read port
// reset (rst, synchronous) clears control, registers and the nearest result; no memory clearing
module nearest_codeword_residual_unit #(
  parameter int NUM_WORDS   = 256,
  parameter int DIM         = 128,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration writes
  input  logic                                   cfg_write,
  input  logic [ncr_pkg::CIDX_W-1:0]             cfg_index,
  input  logic [ncr_pkg::CFG_W-1:0]              cfg_data,
  // item channel
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  logic [ncr_pkg::MODE_W-1:0]             mode,
  input  logic [ncr_pkg::ENTRY_W-1:0]            entry,
  input  logic [ncr_pkg::ELEM_W-1:0]             element,
  input  logic signed [ncr_pkg::VAL_W-1:0]       value,
  // result channel
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic                                   kind,
  output logic [ncr_pkg::IDX_W-1:0]              best_index,
  output logic [ncr_pkg::DIST_W-1:0]             min_distance,
  output logic                                   nonzero_residual,
  output logic signed [ncr_pkg::RES_W-1:0]       residual_value
);
  import ncr_pkg::*;

  // command and status between the sequencer and the datapath
  ncr_cmd_t    cmd;
  ncr_status_t status;

  // sequencer: takes one item per transfer, runs the scan, waits for a free result slot
  ncr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .mode       (mode),
    .status     (status),
    .item_stall (item_stall),
    .cmd        (cmd)
  );

  // datapath: codebook and query memories, squared distance pipeline,
  // best entry tracking and the result register
  ncr_datapath #(
    .NUM_WORDS   (NUM_WORDS),
    .DIM         (DIM),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mode             (mode),
    .entry            (entry),
    .element          (element),
    .value            (value),
    .cmd              (cmd),
    .status           (status),
    .result_stall     (result_stall),
    .result_valid     (result_valid),
    .kind             (kind),
    .best_index       (best_index),
    .min_distance     (min_distance),
    .nonzero_residual (nonzero_residual),
    .residual_value   (residual_value)
  );

`ifndef SYNTHESIS
  // the best entry is committed only after the last square has been summed
  assert property (@(posedge clk) disable iff (rst) cmd.commit |-> status.pipe_empty)
    else $error("commit with distance pipeline still busy");

  // a result is loaded only into a free slot
  assert property (@(posedge clk) disable iff (rst)
    (cmd.load_search || cmd.load_res) |-> status.slot_free)
    else $error("result loaded over a pending transfer");

  // the flag follows the reported distance
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (nonzero_residual == (min_distance != '0)))
    else $error("nonzero flag disagrees with distance");

  // a search result carries no residual
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && (kind == KIND_SEARCH)) |-> (residual_value == '0))
    else $error("search result with residual value");
`endif

endmodule
